@@ rtl/core/vent_window_thermostat_macros.svh @@
// ----------------------------------------------------------------------------
// Vent window thermostat assertion macros
// Property wrappers used by the top-level file that checks this block.
// ----------------------------------------------------------------------------
`ifndef VENT_WINDOW_THERMOSTAT_MACROS_SVH
`define VENT_WINDOW_THERMOSTAT_MACROS_SVH

`ifndef SYNTHESIS
`define VWT_ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vent window thermostat: same-cycle check failed");
`define VWT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vent window thermostat: next-cycle check failed");
`else
`define VWT_ASSERT_IMPLIES(label, pre, post)
`define VWT_ASSERT_NEXT(label, pre, post)
`endif

`endif

@@ rtl/core/vwt_pkg.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat package
// Payload types, state codes and constant thresholds of the block.
// ----------------------------------------------------------------------------
package vwt_pkg;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_ON_HELD  = 2'd1,
    PH_ON       = 2'd2,
    PH_OFF_HELD = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_COLD = 2'd1,
    MODE_WARM = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PAGE_TEMPS     = 2'd0,
    PAGE_POWER     = 2'd1,
    PAGE_SETPOINTS = 2'd2
  } page_t;

  typedef struct packed {
    logic       button;
    logic [5:0] inside_temp;
    logic       switch_a1;
    logic       switch_a2;
    logic       switch_b1;
    logic       switch_b2;
    logic [9:0] stick_x;
    logic [9:0] stick_y;
  } item_t;

  typedef struct packed {
    logic       led_on;
    phase_t     power_phase;
    mode_t      window_mode;
    logic [6:0] servo_b_angle;
    logic [6:0] servo_a_angle;
    logic [5:0] min_setpoint;
    logic [5:0] max_setpoint;
    page_t      display_page;
  } result_t;

  // Joystick zones.
  localparam logic [9:0] STICK_LOW_MAX      = 10'd300;
  localparam logic [9:0] STICK_MID_MIN      = 10'd301;
  localparam logic [9:0] STICK_MID_MAX      = 10'd599;
  localparam logic [9:0] STICK_HIGH_MIN     = 10'd600;
  localparam logic [9:0] STICK_Y_ARM_MAX    = 10'd490;
  localparam logic [9:0] STICK_Y_FIRE_MIN   = 10'd491;
  localparam logic [9:0] STICK_Y_FIRE_MAX   = 10'd559;

  // Servo travel and setpoint limits.
  localparam logic [6:0] ANGLE_MAX          = 7'd90;
  localparam logic [5:0] SETPOINT_RAISE_MAX = 6'd30;
  localparam logic [5:0] SETPOINT_LOWER_MIN = 6'd15;

  // Reset values.
  localparam logic [15:0] PERIOD_RESET      = 16'd100;
  localparam logic [5:0]  LOW_SP_RESET      = 6'd19;
  localparam logic [5:0]  HIGH_SP_RESET     = 6'd24;

  // Gesture arm flags.
  localparam int FLAG_RAISE_MIN = 0;
  localparam int FLAG_LOWER_MIN = 1;
  localparam int FLAG_RAISE_MAX = 2;
  localparam int FLAG_LOWER_MAX = 3;

endpackage

@@ rtl/core/vwt_if.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat channels
// Valid/ready channels for control ticks and for result items.
// ----------------------------------------------------------------------------
interface vwt_item_if;
  logic           valid;
  logic           ready;
  vwt_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vwt_result_if;
  logic             valid;
  logic             ready;
  vwt_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/vwt_in_stage.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat input stage
// Registers one control tick and holds it until the control logic takes it.
// ----------------------------------------------------------------------------
module vwt_in_stage (
  input  logic           clk,
  input  logic           rst,
  vwt_item_if.sink       item,
  input  logic           advance,
  output logic           held_valid,
  output vwt_pkg::item_t held
);

  logic valid;

  assign item.ready = !valid || advance;
  assign held_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held <= item.data;
    end
  end

endmodule

@@ rtl/core/vwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat control
// Holds the thermostat state and computes one tick's update and result.
// ----------------------------------------------------------------------------
module vwt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  logic             advance,
  input  vwt_pkg::item_t   held,
  output vwt_pkg::result_t res
);

  logic [15:0]     period;
  vwt_pkg::phase_t phase;
  logic [15:0]     page_count;
  vwt_pkg::page_t  page;
  logic [15:0]     sample_count;
  vwt_pkg::mode_t  mode;
  logic [6:0]      angle_b;
  logic [6:0]      angle_a;
  logic [5:0]      low_sp;
  logic [5:0]      high_sp;
  logic [3:0]      flags;

  vwt_pkg::phase_t phase_next;
  logic [15:0]     page_count_next;
  vwt_pkg::page_t  page_next;
  logic [15:0]     sample_count_next;
  vwt_pkg::mode_t  mode_next;
  logic [6:0]      angle_b_next;
  logic [6:0]      angle_a_next;
  logic [5:0]      low_sp_next;
  logic [5:0]      high_sp_next;
  logic [3:0]      flags_next;
  logic            led;

  always_comb begin
    logic       power_edge;
    logic       changed;
    logic       a_free;
    logic       b_free;
    logic       x_mid;
    logic       y_mid;
    logic       y_fire;
    logic [6:0] low_p1;
    logic [6:0] low_p2;
    logic [6:0] high_w;

    power_edge = 1'b0;
    changed    = 1'b0;
    a_free     = !held.switch_a1 && !held.switch_a2;
    b_free     = !held.switch_b1 && !held.switch_b2;
    x_mid      = (held.stick_x >= vwt_pkg::STICK_MID_MIN) &&
                 (held.stick_x <= vwt_pkg::STICK_MID_MAX);
    y_mid      = (held.stick_y >= vwt_pkg::STICK_MID_MIN) &&
                 (held.stick_y <= vwt_pkg::STICK_MID_MAX);
    y_fire     = (held.stick_y >= vwt_pkg::STICK_Y_FIRE_MIN) &&
                 (held.stick_y <= vwt_pkg::STICK_Y_FIRE_MAX);
    low_p1     = {1'b0, low_sp} + 7'd1;
    low_p2     = {1'b0, low_sp} + 7'd2;
    high_w     = {1'b0, high_sp};

    // Display page rotation.
    page_count_next = page_count + 16'd1;
    page_next       = page;
    if (page_count_next >= period) begin
      page_count_next = '0;
      unique case (page)
        vwt_pkg::PAGE_TEMPS: page_next = vwt_pkg::PAGE_POWER;
        vwt_pkg::PAGE_POWER: page_next = vwt_pkg::PAGE_SETPOINTS;
        default:             page_next = vwt_pkg::PAGE_TEMPS;
      endcase
    end

    led = (phase == vwt_pkg::PH_ON_HELD) || (phase == vwt_pkg::PH_ON);

    // Power cycle; the phase moves on by at most one step per tick.
    phase_next = phase;
    if (held.button && phase == vwt_pkg::PH_OFF) begin
      phase_next = vwt_pkg::PH_ON_HELD;
      power_edge = 1'b1;
    end else begin
      if (!held.button && phase == vwt_pkg::PH_ON_HELD) begin
        phase_next = vwt_pkg::PH_ON;
      end
      if (held.button && phase_next == vwt_pkg::PH_ON) begin
        phase_next = vwt_pkg::PH_OFF_HELD;
        power_edge = 1'b1;
      end else if (!held.button && phase_next == vwt_pkg::PH_OFF_HELD) begin
        phase_next = vwt_pkg::PH_OFF;
      end
    end
    if (power_edge) begin
      page_next       = vwt_pkg::PAGE_POWER;
      page_count_next = 16'd1;
    end

    // Temperature decision; the mode holds inside the setpoint band.
    sample_count_next = sample_count + 16'd1;
    mode_next         = mode;
    if (sample_count_next == period) begin
      if (low_sp > held.inside_temp) begin
        mode_next = vwt_pkg::MODE_COLD;
      end
      if (high_sp <= held.inside_temp) begin
        mode_next = vwt_pkg::MODE_WARM;
      end
      sample_count_next = '0;
    end

    // Servos step only while the power is on.
    angle_a_next = angle_a;
    angle_b_next = angle_b;
    if (phase_next == vwt_pkg::PH_ON_HELD || phase_next == vwt_pkg::PH_ON) begin
      if (mode_next == vwt_pkg::MODE_COLD) begin
        if (angle_b != 7'd0 && b_free) begin
          angle_b_next = angle_b - 7'd1;
        end
        if (angle_a < vwt_pkg::ANGLE_MAX && a_free) begin
          angle_a_next = angle_a + 7'd1;
        end
      end else if (mode_next == vwt_pkg::MODE_WARM) begin
        if (angle_b < vwt_pkg::ANGLE_MAX && b_free) begin
          angle_b_next = angle_b + 7'd1;
        end
        if (angle_a != 7'd0 && a_free) begin
          angle_a_next = angle_a - 7'd1;
        end
      end
    end

    // Gestures: a stick is armed at one end and fires when it returns to
    // the middle. The first change of the tick ends the checks.
    flags_next   = flags;
    low_sp_next  = low_sp;
    high_sp_next = high_sp;
    if (held.stick_x <= vwt_pkg::STICK_LOW_MAX && !flags[vwt_pkg::FLAG_RAISE_MIN] &&
        low_sp <= vwt_pkg::SETPOINT_RAISE_MAX && low_p2 < high_w) begin
      flags_next[vwt_pkg::FLAG_RAISE_MIN] = 1'b1;
    end
    if (x_mid && flags_next[vwt_pkg::FLAG_RAISE_MIN]) begin
      low_sp_next = low_sp + 6'd1;
      flags_next[vwt_pkg::FLAG_RAISE_MIN] = 1'b0;
      changed = 1'b1;
    end
    if (!changed) begin
      if (held.stick_x >= vwt_pkg::STICK_HIGH_MIN && !flags_next[vwt_pkg::FLAG_LOWER_MIN] &&
          low_sp >= vwt_pkg::SETPOINT_LOWER_MIN && low_p1 < high_w) begin
        flags_next[vwt_pkg::FLAG_LOWER_MIN] = 1'b1;
      end
      if (x_mid && flags_next[vwt_pkg::FLAG_LOWER_MIN]) begin
        low_sp_next = low_sp - 6'd1;
        flags_next[vwt_pkg::FLAG_LOWER_MIN] = 1'b0;
        changed = 1'b1;
      end
    end
    if (!changed) begin
      if (held.stick_y <= vwt_pkg::STICK_Y_ARM_MAX && !flags_next[vwt_pkg::FLAG_RAISE_MAX] &&
          high_sp <= vwt_pkg::SETPOINT_RAISE_MAX && low_p1 < high_w) begin
        flags_next[vwt_pkg::FLAG_RAISE_MAX] = 1'b1;
      end
      if (y_fire && flags_next[vwt_pkg::FLAG_RAISE_MAX]) begin
        high_sp_next = high_sp + 6'd1;
        flags_next[vwt_pkg::FLAG_RAISE_MAX] = 1'b0;
        changed = 1'b1;
      end
    end
    if (!changed) begin
      if (held.stick_y >= vwt_pkg::STICK_HIGH_MIN && !flags_next[vwt_pkg::FLAG_LOWER_MAX] &&
          high_sp >= vwt_pkg::SETPOINT_LOWER_MIN && low_p2 < high_w) begin
        flags_next[vwt_pkg::FLAG_LOWER_MAX] = 1'b1;
      end
      if (y_mid && flags_next[vwt_pkg::FLAG_LOWER_MAX]) begin
        high_sp_next = high_sp - 6'd1;
        flags_next[vwt_pkg::FLAG_LOWER_MAX] = 1'b0;
        changed = 1'b1;
      end
    end
    if (changed) begin
      page_next       = vwt_pkg::PAGE_SETPOINTS;
      page_count_next = 16'd1;
    end
  end

  always_comb begin
    res.led_on        = led;
    res.power_phase   = phase_next;
    res.window_mode   = mode_next;
    res.servo_b_angle = angle_b_next;
    res.servo_a_angle = angle_a_next;
    res.min_setpoint  = low_sp_next;
    res.max_setpoint  = high_sp_next;
    res.display_page  = page_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= vwt_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vwt_pkg::PH_OFF;
      page_count   <= '0;
      page         <= vwt_pkg::PAGE_TEMPS;
      sample_count <= '0;
      mode         <= vwt_pkg::MODE_IDLE;
      angle_b      <= vwt_pkg::ANGLE_MAX;
      angle_a      <= '0;
      low_sp       <= vwt_pkg::LOW_SP_RESET;
      high_sp      <= vwt_pkg::HIGH_SP_RESET;
      flags        <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      page_count   <= page_count_next;
      page         <= page_next;
      sample_count <= sample_count_next;
      mode         <= mode_next;
      angle_b      <= angle_b_next;
      angle_a      <= angle_a_next;
      low_sp       <= low_sp_next;
      high_sp      <= high_sp_next;
      flags        <= flags_next;
    end
  end

endmodule

@@ rtl/core/vwt_out_stage.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat output stage
// Result register; lets the held tick advance whenever it has room.
// ----------------------------------------------------------------------------
module vwt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             held_valid,
  input  vwt_pkg::result_t res,
  output logic             advance,
  vwt_result_if.source     result
);

  assign advance = held_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.data <= res;
    end
  end

endmodule

@@ rtl/core/vent_window_thermostat.sv @@
// ----------------------------------------------------------------------------
// Vent window thermostat
// Power cycle, window mode, vent servos, setpoint gestures and display page.
// ----------------------------------------------------------------------------
// Each transaction on the item channel is one control tick: button level,
// inside temperature, four window switches and two joystick readings. Each
// tick gives exactly one transaction on the result channel with the LED, the
// power phase, the window mode, both servo angles, the setpoints and the
// display page.
// The tick is registered at the input, updated by single-pass logic against
// the thermostat state and captured in the result register. One tick is
// taken every cycle while the receiver takes results; the state update is
// the only path between the two registers. The user must write the period
// register through cfg_we and cfg_data only while the block is idle; the
// block itself does not enforce this. Reset empties both registers and loads
// the state and the period with their initial values. While the receiver
// holds off, the result register keeps its transaction and one more tick
// waits in the input register; item.ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "vent_window_thermostat_macros.svh"

module vent_window_thermostat (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  vwt_item_if.sink     item,
  vwt_result_if.source result
);

  logic             held_valid;
  logic             advance;
  vwt_pkg::item_t   held;
  vwt_pkg::result_t res;

  vwt_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  vwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (advance),
    .held     (held),
    .res      (res)
  );

  vwt_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res        (res),
    .advance    (advance),
    .result     (result)
  );

  // Input backpressure only when both stages are full and the sink stalls.
  `VWT_ASSERT_IMPLIES(a_ready_only_when_full, !item.ready, held_valid && result.valid && !result.ready)
  // A result cannot appear without a tick waiting in the input register.
  `VWT_ASSERT_NEXT(a_no_phantom_result, !result.valid && !held_valid, !result.valid)
  // Both servos stay within their travel.
  `VWT_ASSERT_IMPLIES(a_angle_a, result.valid, result.data.servo_a_angle <= vwt_pkg::ANGLE_MAX)
  `VWT_ASSERT_IMPLIES(a_angle_b, result.valid, result.data.servo_b_angle <= vwt_pkg::ANGLE_MAX)

endmodule
